>>> design/bitmap_page_allocator_assert.svh
// Assertion macros for the bitmap page allocator checker.
// Self-contained; expects a clock i_clk and reset i_rst_n in scope.
`ifndef BITMAP_PAGE_ALLOCATOR_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_ASSERT_SVH

// Condition c must hold in the same cycle as a.
`define BPA_ASSERT_IMPLY(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) \
        else $error("bitmap page allocator assertion failed");

// Condition c must hold in the cycle after a.
`define BPA_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (c)) \
        else $error("bitmap page allocator assertion failed");

`endif

>>> design/bpa_pkg.sv
// Shared constants and controller/datapath interface structs for the
// bitmap page allocator. No dependencies.
`timescale 1ns / 1ps

package bpa_pkg;

    localparam int ADDR_W    = 48;
    localparam int CNT_W     = 13;
    localparam int WORD_BITS = 64;
    localparam int STEP_BITS = 8;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OOM     = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic CFG_BASE  = 1'b0;
    localparam logic CFG_COUNT = 1'b1;

    localparam logic [CNT_W-1:0] POOL_COUNT_RESET = 13'd4096;

    // Controller -> datapath
    typedef struct packed {
        logic clr_wr;
        logic capture;
        logic chk;
        logic scan_init;
        logic load_word;
        logic scan_step;
        logic mark_free;
        logic mark_alloc;
        logic rd_mark;
        logic mark_wr;
        logic mark_next;
        logic set_inv;
        logic set_oom;
        logic set_ok;
        logic load_out;
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic invalid;
        logic is_free;
        logic found;
        logic exhausted;
        logic word_done;
        logic mark_last;
        logic out_free;
    } t_sts;

endpackage

>>> design/bpa_datapath.sv
// Datapath of the bitmap page allocator: bitmap memory, config registers,
// scan and mark logic, output register. Depends on bpa_pkg.
`timescale 1ns / 1ps

module bpa_datapath #(
    parameter int MAX_PAGES  = 4096,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [bpa_pkg::ADDR_W-1:0]    i_cfg_data,
    input  logic                          i_op,
    input  logic [bpa_pkg::CNT_W-1:0]     i_page_count,
    input  logic [bpa_pkg::ADDR_W-1:0]    i_address,
    input  logic                          i_stall,
    output logic [bpa_pkg::ADDR_W-1:0]    o_address_res,
    output logic [1:0]                    o_status,
    output logic                          o_valid,
    input  bpa_pkg::t_cmd                 i_cmd,
    output bpa_pkg::t_sts                 o_sts
);

    localparam int WB   = bpa_pkg::WORD_BITS;
    localparam int STEP = bpa_pkg::STEP_BITS;
    localparam int AW   = bpa_pkg::ADDR_W;
    localparam int NW   = (MAX_PAGES + WB - 1) / WB;
    localparam int WAW  = (NW > 1) ? $clog2(NW) : 1;
    localparam int PW   = $clog2(NW * WB + 1);
    localparam int SH   = $clog2(PAGE_BYTES);
    localparam int LW   = $clog2(WB);

    // Bitmap memory, one row per word of pages
    logic [WB-1:0]  mem [NW];
    logic [WB-1:0]  r_rd_data;
    logic [WAW-1:0] rd_addr;

    // Config registers
    logic [AW-1:0]            r_base;
    logic [bpa_pkg::CNT_W-1:0] r_cfg_cnt;
    logic [PW-1:0]            pool;

    // Request registers
    logic                      r_op;
    logic [bpa_pkg::CNT_W-1:0] r_n;
    logic [AW-1:0]             r_addr;
    logic [AW-1:0]             r_off;
    logic                      r_borrow;
    logic                      r_bad_cnt;

    // Scan and mark state
    logic [PW-1:0]  r_pos, r_run, r_lo, r_hi, hi_m1;
    logic [WB-1:0]  r_word;
    logic [2:0]     r_sub;
    logic [WAW-1:0] r_maddr, r_clr, last_w;
    logic [1:0]     r_res;
    logic           r_out_valid;
    logic [AW-1:0]  r_out_addr;
    logic [1:0]     r_out_st;

    logic [PW-1:0]  s_run, s_first;
    logic           s_found;
    logic [AW-SH-1:0] idx;
    logic [WB-1:0]  mask, new_word;

    // Effective pool size
    always_comb begin
        if (32'(r_cfg_cnt) > MAX_PAGES) pool = PW'(MAX_PAGES);
        else                            pool = PW'(r_cfg_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base    <= '0;
            r_cfg_cnt <= bpa_pkg::POOL_COUNT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == bpa_pkg::CFG_BASE) r_base <= i_cfg_data;
            else                                r_cfg_cnt <= i_cfg_data[bpa_pkg::CNT_W-1:0];
        end
    end

    // Memory read (registered) and write
    assign rd_addr = i_cmd.rd_mark ? r_maddr : r_pos[LW +: WAW];

    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[rd_addr];
        if (i_cmd.clr_wr)       mem[r_clr]   <= '0;
        else if (i_cmd.mark_wr) mem[r_maddr] <= new_word;
    end

    // Clearing sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)          r_clr <= '0;
        else if (i_cmd.clr_wr) r_clr <= r_clr + 1'b1;
    end

    // Request capture and validation
    assign idx = r_off[AW-1:SH];

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_op;
            r_n    <= i_page_count;
            r_addr <= i_address;
        end
        if (i_cmd.chk) begin
            {r_borrow, r_off} <= {1'b0, r_addr} - {1'b0, r_base};
            r_bad_cnt <= (r_n == '0) || (32'(r_n) > 32'(pool));
        end
    end

    assign o_sts.invalid = r_bad_cnt || (r_op == bpa_pkg::OP_FREE &&
        (r_borrow || (AW'(idx) > AW'(pool)) ||
         (32'(r_n) > (32'(pool) - 32'(idx[PW-1:0])))));
    assign o_sts.is_free = (r_op == bpa_pkg::OP_FREE);

    // First-fit scan step over STEP bits
    always_comb begin
        logic [PW-1:0] run, p, first;
        logic          fnd;
        run   = r_run;
        fnd   = 1'b0;
        first = '0;
        for (int b = 0; b < STEP; b++) begin
            p = r_pos + PW'(b);
            if (!fnd && p < pool) begin
                if (r_word[b]) begin
                    run = '0;
                end else begin
                    run = run + 1'b1;
                    if (32'(run) == 32'(r_n)) begin
                        fnd   = 1'b1;
                        first = p + PW'(1) - PW'(r_n);
                    end
                end
            end
        end
        s_run   = run;
        s_found = fnd;
        s_first = first;
    end

    assign o_sts.found     = s_found;
    assign o_sts.exhausted = (32'(r_pos) + STEP) >= 32'(pool);
    assign o_sts.word_done = (r_sub == 3'(STEP - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_pos <= '0;
            r_run <= '0;
        end else if (i_cmd.scan_step) begin
            r_pos <= r_pos + PW'(STEP);
            r_run <= s_run;
        end
        if (i_cmd.load_word) begin
            r_word <= r_rd_data;
            r_sub  <= '0;
        end else if (i_cmd.scan_step) begin
            r_word <= r_word >> STEP;
            r_sub  <= r_sub + 1'b1;
        end
    end

    // Run bounds and word-by-word marking
    always_ff @(posedge i_clk) begin
        if (i_cmd.mark_free) begin
            r_lo    <= idx[PW-1:0];
            r_hi    <= idx[PW-1:0] + PW'(r_n);
            r_maddr <= idx[LW +: WAW];
        end else if (i_cmd.mark_alloc) begin
            r_lo    <= s_first;
            r_hi    <= s_first + PW'(r_n);
            r_maddr <= s_first[LW +: WAW];
        end else if (i_cmd.mark_next) begin
            r_maddr <= r_maddr + 1'b1;
        end
    end

    assign hi_m1          = r_hi - PW'(1);
    assign last_w         = hi_m1[LW +: WAW];
    assign o_sts.mark_last = (r_maddr == last_w);

    always_comb begin
        logic [PW-1:0] wbase;
        wbase = PW'({r_maddr, LW'(0)});
        for (int j = 0; j < WB; j++) begin
            mask[j] = ((wbase + PW'(j)) >= r_lo) && ((wbase + PW'(j)) < r_hi);
        end
        if (r_op == bpa_pkg::OP_FREE) new_word = r_rd_data & ~mask;
        else                          new_word = r_rd_data | mask;
    end

    // Result status
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_inv)      r_res <= bpa_pkg::ST_INVALID;
        else if (i_cmd.set_oom) r_res <= bpa_pkg::ST_OOM;
        else if (i_cmd.set_ok)  r_res <= bpa_pkg::ST_OK;
    end

    // Output register
    assign o_sts.clr_last = (r_clr == WAW'(NW - 1));
    assign o_sts.out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)            r_out_valid <= 1'b0;
        else if (i_cmd.load_out) r_out_valid <= 1'b1;
        else if (!i_stall)       r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_st <= r_res;
            if (r_res == bpa_pkg::ST_OK && r_op == bpa_pkg::OP_ALLOC)
                r_out_addr <= r_base + (AW'(r_lo) << SH);
            else
                r_out_addr <= '0;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_address_res = r_out_addr;
    assign o_status      = r_out_st;

endmodule

>>> design/bpa_ctrl.sv
// Controller state machine of the bitmap page allocator.
// Depends on bpa_pkg for the command and status structs.
`timescale 1ns / 1ps

module bpa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  bpa_pkg::t_sts i_sts,
    output bpa_pkg::t_cmd o_cmd
);

    typedef enum logic [9:0] {
        S_CLR  = 10'b00_0000_0001,
        S_IDLE = 10'b00_0000_0010,
        S_CHK  = 10'b00_0000_0100,
        S_VAL  = 10'b00_0000_1000,
        S_SRD  = 10'b00_0001_0000,
        S_SLD  = 10'b00_0010_0000,
        S_SCAN = 10'b00_0100_0000,
        S_MRD  = 10'b00_1000_0000,
        S_MWR  = 10'b01_0000_0000,
        S_FIN  = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLR;
        else          r_state <= n_state;
    end

    assign o_stall = (r_state != S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_CHK;
                end
            end
            S_CHK: begin
                o_cmd.chk = 1'b1;
                n_state   = S_VAL;
            end
            S_VAL: begin
                priority if (i_sts.invalid) begin
                    o_cmd.set_inv = 1'b1;
                    n_state       = S_FIN;
                end else if (i_sts.is_free) begin
                    o_cmd.mark_free = 1'b1;
                    n_state         = S_MRD;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SRD;
                end
            end
            S_SRD: n_state = S_SLD;
            S_SLD: begin
                o_cmd.load_word = 1'b1;
                n_state         = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                priority if (i_sts.found) begin
                    o_cmd.mark_alloc = 1'b1;
                    n_state          = S_MRD;
                end else if (i_sts.exhausted) begin
                    o_cmd.set_oom = 1'b1;
                    n_state       = S_FIN;
                end else if (i_sts.word_done) begin
                    n_state = S_SRD;
                end
            end
            S_MRD: begin
                o_cmd.rd_mark = 1'b1;
                n_state       = S_MWR;
            end
            S_MWR: begin
                o_cmd.rd_mark = 1'b1;
                o_cmd.mark_wr = 1'b1;
                if (i_sts.mark_last) begin
                    o_cmd.set_ok = 1'b1;
                    n_state      = S_FIN;
                end else begin
                    o_cmd.mark_next = 1'b1;
                    n_state         = S_MRD;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_CLR;
        endcase
    end

endmodule

>>> design/bitmap_page_allocator.sv
// Bitmap first-fit page frame allocator, top level.
// Instantiates bpa_ctrl and bpa_datapath; depends on bpa_pkg.
//
// Request channel: i_valid / o_stall carry op, page_count, address. One
// request is taken at a time; o_stall is low only while the block is idle.
// Result channel: o_valid / i_stall carry address_res and status, one
// result per request, held in an output register so the next request can
// be taken while a result still waits.
// Sequence: the CHK and VAL states check the request, then a free reads and
// writes each bitmap word touched (S_MRD, S_MWR); an allocate scans 8 pages a
// cycle in S_SCAN through each 64-page word read from the bitmap memory,
// with S_SRD and S_SLD between words, then reads and writes each word
// marked; S_FIN then loads the result.
// Reset: a clearing pass writes zero to each of the MAX_PAGES/64 words, one
// per cycle, with o_stall high; config writes are taken during it. Pool
// registers reset to base 0 and count 4096.
// A stalled receiver holds the result; the block finishes its current
// request and waits with it until the output register frees.
`timescale 1ns / 1ps

module bitmap_page_allocator #(
    parameter int MAX_PAGES  = 4096,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [bpa_pkg::ADDR_W-1:0] i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_op,
    input  logic [bpa_pkg::CNT_W-1:0]  i_page_count,
    input  logic [bpa_pkg::ADDR_W-1:0] i_address,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [bpa_pkg::ADDR_W-1:0] o_address_res,
    output logic [1:0]                 o_status
);

    bpa_pkg::t_cmd cmd;
    bpa_pkg::t_sts sts;

    bpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    bpa_datapath #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_op          (i_op),
        .i_page_count  (i_page_count),
        .i_address     (i_address),
        .i_stall       (i_stall),
        .o_address_res (o_address_res),
        .o_status      (o_status),
        .o_valid       (o_valid),
        .i_cmd         (cmd),
        .o_sts         (sts)
    );

endmodule

>>> design/bpa_checker.sv
// Port-level checker for the bitmap page allocator, bound to the top level.
// Uses the macros in bitmap_page_allocator_assert.svh.
`timescale 1ns / 1ps
`include "bitmap_page_allocator_assert.svh"

module bpa_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic [bpa_pkg::ADDR_W-1:0] o_address_res,
    input logic [1:0]                 o_status
);

    // A stalled result stays offered and unchanged
    `BPA_ASSERT_NEXT(a_hold_valid, o_valid && i_stall, o_valid)
    `BPA_ASSERT_NEXT(a_hold_data, o_valid && i_stall, $stable(o_address_res) && $stable(o_status))
    // Only defined status codes appear
    `BPA_ASSERT_IMPLY(a_status_code, o_valid, o_status <= bpa_pkg::ST_INVALID)
    // Failed requests report a zero address
    `BPA_ASSERT_IMPLY(a_zero_addr, o_valid && o_status != bpa_pkg::ST_OK, o_address_res == '0)

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (.*);
